@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared constants, sextant codes and helper functions for the HSV/RGB to RGB888 pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned STAGES    = 9;
  localparam int unsigned DEG_SPAN  = 360;
  localparam int unsigned DEG_W     = 9;
  localparam int unsigned SEXT_DEG  = 60;
  localparam int unsigned RAMP_BIAS = 30;

  // floor(2^32 / 360)
  localparam logic [23:0] HUE_RECIP = 24'd11930464;

  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sextant_e;

  function automatic sextant_e sextant_of(input logic [DEG_W-1:0] deg);
    sextant_e res;
    if (deg < DEG_W'(60)) begin
      res = SEXT_RY;
    end else if (deg < DEG_W'(120)) begin
      res = SEXT_YG;
    end else if (deg < DEG_W'(180)) begin
      res = SEXT_GC;
    end else if (deg < DEG_W'(240)) begin
      res = SEXT_CB;
    end else if (deg < DEG_W'(300)) begin
      res = SEXT_BM;
    end else begin
      res = SEXT_MR;
    end
    return res;
  endfunction

  function automatic logic [DEG_W-1:0] sextant_base(input sextant_e sext);
    logic [DEG_W-1:0] res;
    case (sext)
      SEXT_RY: res = DEG_W'(0);
      SEXT_YG: res = DEG_W'(60);
      SEXT_GC: res = DEG_W'(120);
      SEXT_CB: res = DEG_W'(180);
      SEXT_BM: res = DEG_W'(240);
      SEXT_MR: res = DEG_W'(300);
      default: res = DEG_W'(0);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hsv2rgb_front.sv @@
// Stages 1-3: input clamps, hue reduction to whole degrees in [0,360) and chroma.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic [2:0]                            ld_i,
  input  wire logic                                  mode_i,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_a_i,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_b_i,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_c_i,
  output logic                                       mode_o,
  output logic [hsv2rgb_pkg::DEG_W-1:0]              hue_deg_o,
  output logic [FRAC_BITS-1:0]                       hue_frac_o,
  output logic [FRAC_BITS:0]                         chroma_o,
  output logic [FRAC_BITS:0]                         ca_o,
  output logic [FRAC_BITS:0]                         cb_o,
  output logic [FRAC_BITS:0]                         cc_o
);

  localparam int unsigned UNIT_W  = FRAC_BITS + 1;
  localparam int unsigned ONE     = 1 << FRAC_BITS;
  localparam int unsigned HALF    = 1 << (FRAC_BITS - 1);
  localparam int unsigned WW      = hsv2rgb_pkg::WORD_W;
  localparam int unsigned DS      = hsv2rgb_pkg::DEG_SPAN;
  localparam int unsigned HUE_OFF = DS * (((1 << (31 - FRAC_BITS)) + DS - 1) / DS);
  localparam int unsigned UW      = 34 - FRAC_BITS;
  localparam int unsigned QPW     = UW + 24;
  localparam int unsigned QW      = UW - 8;
  localparam int unsigned CPW     = 2 * UNIT_W;
  localparam int unsigned DW      = hsv2rgb_pkg::DEG_W;
  localparam logic [WW-1:0] ONE_W = WW'(ONE);

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [WW-1:0] x);
    logic [UNIT_W-1:0] res;
    if (x[WW-1]) begin
      res = '0;
    end else if ($unsigned(x) > ONE_W) begin
      res = UNIT_W'(ONE);
    end else begin
      res = x[UNIT_W-1:0];
    end
    return res;
  endfunction

  // stage 1
  logic signed [WW-1:0] hue_int;
  logic [WW-1:0]        hue_sum;
  logic                 mode1_q;
  logic [UW-1:0]        u1_q;
  logic [FRAC_BITS-1:0] frac1_q;
  logic [UNIT_W-1:0]    ca1_q, cb1_q, cc1_q;

  assign hue_int = chan_a_i >>> FRAC_BITS;
  assign hue_sum = $unsigned(hue_int) + WW'(HUE_OFF);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mode1_q <= mode_i;
      u1_q    <= hue_sum[UW-1:0];
      frac1_q <= chan_a_i[FRAC_BITS-1:0];
      ca1_q   <= clamp_unit(chan_a_i);
      cb1_q   <= clamp_unit(chan_b_i);
      cc1_q   <= clamp_unit(chan_c_i);
    end
  end

  // stage 2
  logic [QPW-1:0]       qprod;
  logic [CPW-1:0]       vs_rnd;
  logic                 mode2_q;
  logic [UW-1:0]        u2_q;
  logic [QW-1:0]        q2_q;
  logic [FRAC_BITS-1:0] frac2_q;
  logic [UNIT_W-1:0]    ch2_q, ca2_q, cb2_q, cc2_q;

  assign qprod  = QPW'(u1_q) * QPW'(hsv2rgb_pkg::HUE_RECIP);
  assign vs_rnd = CPW'(cc1_q) * CPW'(cb1_q) + CPW'(HALF);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      mode2_q <= mode1_q;
      u2_q    <= u1_q;
      q2_q    <= qprod[QPW-1:32];
      frac2_q <= frac1_q;
      ch2_q   <= vs_rnd[FRAC_BITS +: UNIT_W];
      ca2_q   <= ca1_q;
      cb2_q   <= cb1_q;
      cc2_q   <= cc1_q;
    end
  end

  // stage 3
  logic [UW-1:0]        rem_raw;
  logic [9:0]           rem_lo;
  logic [DW-1:0]        deg_d;
  logic                 mode3_q;
  logic [DW-1:0]        deg3_q;
  logic [FRAC_BITS-1:0] frac3_q;
  logic [UNIT_W-1:0]    ch3_q, ca3_q, cb3_q, cc3_q;

  assign rem_raw = u2_q - UW'(q2_q) * UW'(DS);
  assign rem_lo  = rem_raw[9:0];

  always_comb begin
    if (rem_lo >= 10'(DS)) begin
      deg_d = DW'(rem_lo - 10'(DS));
    end else begin
      deg_d = rem_lo[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      mode3_q <= mode2_q;
      deg3_q  <= deg_d;
      frac3_q <= frac2_q;
      ch3_q   <= ch2_q;
      ca3_q   <= ca2_q;
      cb3_q   <= cb2_q;
      cc3_q   <= cc2_q;
    end
  end

  assign mode_o     = mode3_q;
  assign hue_deg_o  = deg3_q;
  assign hue_frac_o = frac3_q;
  assign chroma_o   = ch3_q;
  assign ca_o       = ca3_q;
  assign cb_o       = cb3_q;
  assign cc_o       = cc3_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_ramp.sv @@
// Stages 4-7: sextant pick, ramp fraction by constant division, second component.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_ramp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [3:0]                    ld_i,
  input  wire logic                          mode_i,
  input  wire logic [hsv2rgb_pkg::DEG_W-1:0] hue_deg_i,
  input  wire logic [FRAC_BITS-1:0]          hue_frac_i,
  input  wire logic [FRAC_BITS:0]            chroma_i,
  input  wire logic [FRAC_BITS:0]            ca_i,
  input  wire logic [FRAC_BITS:0]            cb_i,
  input  wire logic [FRAC_BITS:0]            cc_i,
  output logic                               mode_o,
  output hsv2rgb_pkg::sextant_e              sext_o,
  output logic [FRAC_BITS:0]                 chroma_o,
  output logic [FRAC_BITS:0]                 x_o,
  output logic [FRAC_BITS:0]                 ca_o,
  output logic [FRAC_BITS:0]                 cb_o,
  output logic [FRAC_BITS:0]                 cc_o
);

  localparam int unsigned UNIT_W = FRAC_BITS + 1;
  localparam int unsigned ONE    = 1 << FRAC_BITS;
  localparam int unsigned HALF   = 1 << (FRAC_BITS - 1);
  localparam int unsigned TW     = FRAC_BITS + 6;
  localparam int unsigned NW     = FRAC_BITS + 7;
  localparam int unsigned MW     = NW - 5;
  localparam int unsigned PW     = NW + MW;
  localparam int unsigned XPW    = 2 * UNIT_W;
  localparam int unsigned DW     = hsv2rgb_pkg::DEG_W;
  localparam int unsigned SD     = hsv2rgb_pkg::SEXT_DEG;
  localparam longint unsigned RECIP60 = (longint'(1) << NW) / SD;
  localparam logic [TW-1:0] SPAN_FX = TW'(SD * ONE);

  // stage 4
  hsv2rgb_pkg::sextant_e sext4_d;
  logic [DW-1:0]         deg_off;
  logic [TW-1:0]         rem;
  logic [TW-1:0]         tn4_d;
  logic                  mode4_q;
  hsv2rgb_pkg::sextant_e sext4_q;
  logic [TW-1:0]         tn4_q;
  logic [UNIT_W-1:0]     ch4_q, ca4_q, cb4_q, cc4_q;

  assign sext4_d = hsv2rgb_pkg::sextant_of(hue_deg_i);
  assign deg_off = hue_deg_i - hsv2rgb_pkg::sextant_base(sext4_d);
  assign rem     = {deg_off[5:0], hue_frac_i};

  always_comb begin
    if (sext4_d inside {hsv2rgb_pkg::SEXT_YG, hsv2rgb_pkg::SEXT_CB, hsv2rgb_pkg::SEXT_MR}) begin
      tn4_d = SPAN_FX - rem;
    end else begin
      tn4_d = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mode4_q <= mode_i;
      sext4_q <= sext4_d;
      tn4_q   <= tn4_d;
      ch4_q   <= chroma_i;
      ca4_q   <= ca_i;
      cb4_q   <= cb_i;
      cc4_q   <= cc_i;
    end
  end

  // stage 5: estimate (tn + 30) / 60, low by at most one
  logic [NW-1:0]         num;
  logic [PW-1:0]         qprod;
  logic                  mode5_q;
  hsv2rgb_pkg::sextant_e sext5_q;
  logic [NW-1:0]         n5_q;
  logic [MW-1:0]         est5_q;
  logic [UNIT_W-1:0]     ch5_q, ca5_q, cb5_q, cc5_q;

  assign num   = NW'(tn4_q) + NW'(hsv2rgb_pkg::RAMP_BIAS);
  assign qprod = PW'(num) * PW'(RECIP60);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      mode5_q <= mode4_q;
      sext5_q <= sext4_q;
      n5_q    <= num;
      est5_q  <= qprod[PW-1:NW];
      ch5_q   <= ch4_q;
      ca5_q   <= ca4_q;
      cb5_q   <= cb4_q;
      cc5_q   <= cc4_q;
    end
  end

  // stage 6: correct the estimate
  logic [NW-1:0]         rm;
  logic [MW-1:0]         t_wide;
  logic                  mode6_q;
  hsv2rgb_pkg::sextant_e sext6_q;
  logic [UNIT_W-1:0]     t6_q;
  logic [UNIT_W-1:0]     ch6_q, ca6_q, cb6_q, cc6_q;

  assign rm = n5_q - NW'(est5_q) * NW'(SD);

  always_comb begin
    if (rm >= NW'(SD)) begin
      t_wide = est5_q + MW'(1);
    end else begin
      t_wide = est5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      mode6_q <= mode5_q;
      sext6_q <= sext5_q;
      t6_q    <= t_wide[UNIT_W-1:0];
      ch6_q   <= ch5_q;
      ca6_q   <= ca5_q;
      cb6_q   <= cb5_q;
      cc6_q   <= cc5_q;
    end
  end

  // stage 7
  logic [XPW-1:0]        xprod;
  logic                  mode7_q;
  hsv2rgb_pkg::sextant_e sext7_q;
  logic [UNIT_W-1:0]     x7_q;
  logic [UNIT_W-1:0]     ch7_q, ca7_q, cb7_q, cc7_q;

  assign xprod = XPW'(ch6_q) * XPW'(t6_q) + XPW'(HALF);

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      mode7_q <= mode6_q;
      sext7_q <= sext6_q;
      x7_q    <= xprod[FRAC_BITS +: UNIT_W];
      ch7_q   <= ch6_q;
      ca7_q   <= ca6_q;
      cb7_q   <= cb6_q;
      cc7_q   <= cc6_q;
    end
  end

  assign mode_o   = mode7_q;
  assign sext_o   = sext7_q;
  assign chroma_o = ch7_q;
  assign x_o      = x7_q;
  assign ca_o     = ca7_q;
  assign cb_o     = cb7_q;
  assign cc_o     = cc7_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv2rgb_mix.sv @@
// Stages 8-9: channel by sextant plus offset (RGB mode: clamped inputs), then scale and round to 8 bits.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_mix #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_MAX   = 255
) (
  input  wire logic                         clk_i,
  input  wire logic [1:0]                   ld_i,
  input  wire logic                         mode_i,
  input  wire hsv2rgb_pkg::sextant_e        sext_i,
  input  wire logic [FRAC_BITS:0]           chroma_i,
  input  wire logic [FRAC_BITS:0]           x_i,
  input  wire logic [FRAC_BITS:0]           ca_i,
  input  wire logic [FRAC_BITS:0]           cb_i,
  input  wire logic [FRAC_BITS:0]           cc_i,
  output logic [hsv2rgb_pkg::OUT_W-1:0]     red_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]     green_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]     blue_o
);

  localparam int unsigned UNIT_W = FRAC_BITS + 1;
  localparam int unsigned HALF   = 1 << (FRAC_BITS - 1);
  localparam int unsigned SW     = FRAC_BITS + 17;
  localparam int unsigned OW     = hsv2rgb_pkg::OUT_W;

  function automatic logic [OW-1:0] scale_out(input logic [UNIT_W-1:0] val);
    logic [SW-1:0] prod;
    prod = SW'(val) * SW'(OUT_MAX) + SW'(HALF);
    return prod[FRAC_BITS +: OW];
  endfunction

  // stage 8
  logic [UNIT_W-1:0] offs;
  logic [UNIT_W-1:0] r_base, g_base, b_base;
  logic [UNIT_W-1:0] r8_d, g8_d, b8_d;
  logic [UNIT_W-1:0] r8_q, g8_q, b8_q;

  assign offs = cc_i - chroma_i;

  always_comb begin
    r_base = '0;
    g_base = '0;
    b_base = '0;
    case (sext_i)
      hsv2rgb_pkg::SEXT_RY: begin
        r_base = chroma_i;
        g_base = x_i;
      end
      hsv2rgb_pkg::SEXT_YG: begin
        r_base = x_i;
        g_base = chroma_i;
      end
      hsv2rgb_pkg::SEXT_GC: begin
        g_base = chroma_i;
        b_base = x_i;
      end
      hsv2rgb_pkg::SEXT_CB: begin
        g_base = x_i;
        b_base = chroma_i;
      end
      hsv2rgb_pkg::SEXT_BM: begin
        r_base = x_i;
        b_base = chroma_i;
      end
      hsv2rgb_pkg::SEXT_MR: begin
        r_base = chroma_i;
        b_base = x_i;
      end
      default: begin
        r_base = '0;
        g_base = '0;
        b_base = '0;
      end
    endcase
  end

  always_comb begin
    if (mode_i) begin
      r8_d = r_base + offs;
      g8_d = g_base + offs;
      b8_d = b_base + offs;
    end else begin
      r8_d = ca_i;
      g8_d = cb_i;
      b8_d = cc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      r8_q <= r8_d;
      g8_q <= g8_d;
      b8_q <= b8_d;
    end
  end

  // stage 9: output register
  logic [OW-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      red_q   <= scale_out(r8_q);
      green_q <= scale_out(g8_q);
      blue_q  <= scale_out(b8_q);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

@@ hw/rtl/hsv_or_rgb_to_rgb888.sv @@
// Top level: HSV or RGB Q16.16 words to RGB888, nine-stage pipeline with per-stage valids.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_ramp, hsv2rgb_mix.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   in       | in_valid_i / in_stall_o | chan_a_i, chan_b_i, chan_c_i
//   out      | out_valid_o / out_stall_i | red_o, green_o, blue_o
//   cfg      | cfg_we_i               | cfg_wdata_i (hsv_mode)
//
// One word per cycle sustained while out_stall_i is low.
// The pipeline depth is set by the chain of hue reduction, divide-by-60 and the multiplies.
// Reset clears all stage valids and sets hsv_mode to 1; payload registers are not reset.
// A stall holds only the stages that are full up to the output; empty stages keep filling.
// in_stall_o rises only when every stage holds a word and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module hsv_or_rgb_to_rgb888 #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_MAX   = 255
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_a_i,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_b_i,
  input  wire logic signed [hsv2rgb_pkg::WORD_W-1:0] chan_c_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [hsv2rgb_pkg::OUT_W-1:0]              red_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]              green_o,
  output logic [hsv2rgb_pkg::OUT_W-1:0]              blue_o
);

  localparam int unsigned NS = hsv2rgb_pkg::STAGES;

  logic hsv_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      hsv_mode_q <= cfg_wdata_i;
    end
  end

  logic [NS-1:0] valid_q, valid_d, ready, prev_valid;

  always_comb begin
    ready[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
  end

  assign prev_valid = {valid_q[NS-2:0], in_valid_i};
  assign valid_d    = (ready & prev_valid) | (~ready & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NS-1];

  logic                  f_mode;
  logic [hsv2rgb_pkg::DEG_W-1:0] f_deg;
  logic [FRAC_BITS-1:0]  f_frac;
  logic [FRAC_BITS:0]    f_ch, f_ca, f_cb, f_cc;

  hsv2rgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .ld_i      (ready[2:0]),
    .mode_i    (hsv_mode_q),
    .chan_a_i  (chan_a_i),
    .chan_b_i  (chan_b_i),
    .chan_c_i  (chan_c_i),
    .mode_o    (f_mode),
    .hue_deg_o (f_deg),
    .hue_frac_o(f_frac),
    .chroma_o  (f_ch),
    .ca_o      (f_ca),
    .cb_o      (f_cb),
    .cc_o      (f_cc)
  );

  logic                  r_mode;
  hsv2rgb_pkg::sextant_e r_sext;
  logic [FRAC_BITS:0]    r_ch, r_x, r_ca, r_cb, r_cc;

  hsv2rgb_ramp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ramp (
    .clk_i     (clk_i),
    .ld_i      (ready[6:3]),
    .mode_i    (f_mode),
    .hue_deg_i (f_deg),
    .hue_frac_i(f_frac),
    .chroma_i  (f_ch),
    .ca_i      (f_ca),
    .cb_i      (f_cb),
    .cc_i      (f_cc),
    .mode_o    (r_mode),
    .sext_o    (r_sext),
    .chroma_o  (r_ch),
    .x_o       (r_x),
    .ca_o      (r_ca),
    .cb_o      (r_cb),
    .cc_o      (r_cc)
  );

  hsv2rgb_mix #(
    .FRAC_BITS(FRAC_BITS),
    .OUT_MAX  (OUT_MAX)
  ) u_mix (
    .clk_i   (clk_i),
    .ld_i    (ready[8:7]),
    .mode_i  (r_mode),
    .sext_i  (r_sext),
    .chroma_i(r_ch),
    .x_i     (r_x),
    .ca_i    (r_ca),
    .cb_i    (r_cb),
    .cc_i    (r_cc),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(valid_q) ==
      $countones($past(valid_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy does not match accepted words");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && out_stall_i |-> in_stall_o)
    else $error("full pipeline took a word under output stall");

  a_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NS-1] |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (valid_q == '0) |-> ##9 out_valid_o)
    else $error("word into an empty pipeline did not arrive after nine cycles");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for hsv_or_rgb_to_rgb888: drives HSV and RGB Q16.16 words,
// predicts each RGB888 word and checks the outputs in order, with random stalls on both sides.
// Depends on hsv2rgb_pkg and the hsv_or_rgb_to_rgb888 RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC     = 16;
  localparam int unsigned PIX_MAX  = 255;
  localparam int unsigned LATENCY  = 9;
  localparam int unsigned IDLE_CAP = 2000;
  localparam int unsigned HOLD_LEN = 80;
  localparam logic [31:0] ONE_Q    = 32'h0001_0000;
  localparam logic [31:0] DEG_Q    = 32'h0001_0000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb888_t;

  class rgb888_ledger;
    rgb888_t     due_pixels[$];
    bit          hsv_mode;
    int unsigned failures;

    function new();
      hsv_mode = 1'b1;
      failures = 0;
    endfunction

    function logic [63:0] unit_clamp(logic signed [31:0] x);
      if (x < 0) return 64'd0;
      if (x > $signed(ONE_Q)) return 64'(ONE_Q);
      return 64'($unsigned(x));
    endfunction

    function logic [7:0] to_byte(logic [63:0] frac);
      logic [63:0] p;
      p = (frac * 64'(PIX_MAX) + (64'd1 << (FRAC - 1))) >> FRAC;
      return p[7:0];
    endfunction

    function rgb888_t hsv_to_rgb888(logic signed [31:0] a, logic signed [31:0] b,
                                    logic signed [31:0] c);
      longint      span_q, sext_q, hue, k;
      logic [63:0] s, v, ch, x, m, rem, tn, t, r, g, bl;
      rgb888_t     px;
      if (!hsv_mode) begin
        r  = unit_clamp(a);
        g  = unit_clamp(b);
        bl = unit_clamp(c);
      end else begin
        span_q = longint'(hsv2rgb_pkg::DEG_SPAN) << FRAC;
        sext_q = longint'(hsv2rgb_pkg::SEXT_DEG) << FRAC;
        hue = longint'(a) % span_q;
        if (hue < 0) hue += span_q;
        s   = unit_clamp(b);
        v   = unit_clamp(c);
        ch  = (v * s + (64'd1 << (FRAC - 1))) >> FRAC;
        k   = hue / sext_q;
        rem = 64'(hue - k * sext_q);
        tn  = k[0] ? 64'(sext_q) - rem : rem;
        t   = (tn + 64'(hsv2rgb_pkg::RAMP_BIAS)) / 64'(hsv2rgb_pkg::SEXT_DEG);
        x   = (ch * t + (64'd1 << (FRAC - 1))) >> FRAC;
        m   = v - ch;
        r = 64'd0;
        g = 64'd0;
        bl = 64'd0;
        case (hsv2rgb_pkg::sextant_e'(k[2:0]))
          hsv2rgb_pkg::SEXT_RY: begin r = ch; g = x; end
          hsv2rgb_pkg::SEXT_YG: begin r = x; g = ch; end
          hsv2rgb_pkg::SEXT_GC: begin g = ch; bl = x; end
          hsv2rgb_pkg::SEXT_CB: begin g = x; bl = ch; end
          hsv2rgb_pkg::SEXT_BM: begin r = x; bl = ch; end
          default: begin r = ch; bl = x; end
        endcase
        r  = r + m;
        g  = g + m;
        bl = bl + m;
      end
      px.red   = to_byte(r);
      px.green = to_byte(g);
      px.blue  = to_byte(bl);
      return px;
    endfunction

    function void note_word(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      due_pixels.push_back(hsv_to_rgb888(a, b, c));
    endfunction

    function void check_word(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
      rgb888_t want;
      if (due_pixels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected output word r=%0d g=%0d b=%0d", r, g, bl);
        return;
      end
      want = due_pixels.pop_front();
      if (want.red !== r || want.green !== g || want.blue !== bl) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, r, g, bl);
      end
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid  = 1'b0;
  logic [31:0] chan_a    = '0;
  logic [31:0] chan_b    = '0;
  logic [31:0] chan_c    = '0;
  logic        out_stall = 1'b0;
  logic        calm      = 1'b0;
  logic        hold_req  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  red, green, blue;

  rgb888_ledger ledger = new();

  hsv_or_rgb_to_rgb888 #(
    .FRAC_BITS(FRAC),
    .OUT_MAX  (PIX_MAX)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .chan_a_i   (chan_a),
    .chan_b_i   (chan_b),
    .chan_c_i   (chan_c),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue)
  );

  always #1 clk = ~clk;

  initial begin : rx_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_word(red, green, blue);
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_CAP) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  task automatic send_word(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    chan_a <= a;
    chan_b <= b;
    chan_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_word(a, b, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.hsv_mode = mode;
  endtask

  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'($urandom_range(0, 16));
      2: return ONE_Q - 32'($urandom_range(0, 16));
      default: return 32'($urandom_range(0, 65536 + 16384)) - 32'd8192;
    endcase
  endfunction

  function automatic logic [31:0] pick_hue();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'($urandom_range(0, 6)) * 32'(hsv2rgb_pkg::SEXT_DEG) * DEG_Q
                + 32'($urandom_range(0, 4)) - 32'd2;
      default: return 32'($urandom_range(0, 720 * 65536 - 1)) - 32'(360 * 65536);
    endcase
  endfunction

  task automatic run_random(input int count, input int calm_from, input int calm_to,
                            input int hold_at, input int pause_at);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      if (i == calm_from) calm <= 1'b1;
      if (i == calm_to) calm <= 1'b0;
      if (i == hold_at) hold_req <= 1'b1;
      if (i == pause_at) drain();
      a = ledger.hsv_mode ? pick_hue() : pick_fraction();
      send_word(a, pick_fraction(), pick_fraction());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hsv mode out of reset: sextant corners, hue wrap, clamps
    send_word(32'h0, ONE_Q, ONE_Q);
    send_word(60 * DEG_Q, ONE_Q, ONE_Q);
    send_word(120 * DEG_Q, ONE_Q, ONE_Q);
    send_word(180 * DEG_Q, ONE_Q, ONE_Q);
    send_word(240 * DEG_Q, ONE_Q, ONE_Q);
    send_word(300 * DEG_Q, ONE_Q, ONE_Q);
    send_word(360 * DEG_Q - 32'd1, ONE_Q, ONE_Q);
    send_word(-(60 * DEG_Q), ONE_Q, 32'h0000_8000);
    send_word(720 * DEG_Q, 32'h0000_8000, ONE_Q);
    send_word(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0002_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h001E_8000, 32'h0000_8000, 32'h0000_C000);
    send_word(32'h00D2_4000, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    write_mode(1'b0);
    send_word(32'h0, 32'h0, 32'h0);
    send_word(ONE_Q, ONE_Q, ONE_Q);
    send_word(32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_8000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, ONE_Q + 32'd1);
    send_word(32'h0000_0080, 32'h0000_0081, 32'h0000_007F);
    send_word(32'h0000_FF7F, 32'h0000_FF80, 32'h0000_0101);
    drain();

    write_mode(1'b1);
    run_random(300, 150, 230, 60, 250);
    drain();

    write_mode(1'b0);
    run_random(200, 20, 80, -1, -1);
    drain();

    write_mode(1'b1);
    run_random(300, -1, -1, -1, -1);
    drain();

    if (ledger.failures == 0 && ledger.pending() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_ramp.sv
hw/rtl/hsv2rgb_mix.sv
hw/rtl/hsv_or_rgb_to_rgb888.sv
dv/testbench.sv
